// ===== rtl/core/ngga_pkg.sv =====
// Shared types, codes and lookup functions for the GGA sentence parser.
// No dependencies; imported by every module of the block.
package ngga_pkg;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_HEAD,
    PH_FIELDS,
    PH_CK_HI,
    PH_CK_LO,
    PH_CK_LO_BAD
  } phase_t;

  localparam logic [1:0] ST_VALID      = 2'd0;
  localparam logic [1:0] ST_BAD_HEADER = 2'd1;
  localparam logic [1:0] ST_BAD_CKSUM  = 2'd2;

  localparam logic [3:0] FLD_HEADER    = 4'd0;
  localparam logic [3:0] FLD_TIME      = 4'd1;
  localparam logic [3:0] FLD_LAT       = 4'd2;
  localparam logic [3:0] FLD_LAT_DIR   = 4'd3;
  localparam logic [3:0] FLD_LON       = 4'd4;
  localparam logic [3:0] FLD_LON_DIR   = 4'd5;
  localparam logic [3:0] FLD_QUALITY   = 4'd6;
  localparam logic [3:0] FLD_SATS      = 4'd7;
  localparam logic [3:0] FLD_HDOP      = 4'd8;
  localparam logic [3:0] FLD_ALT       = 4'd9;
  localparam logic [3:0] FLD_ALT_UNIT  = 4'd10;
  localparam logic [3:0] FLD_GEOID     = 4'd11;
  localparam logic [3:0] FLD_GEO_UNIT  = 4'd12;
  localparam logic [3:0] FLD_AGE       = 4'd13;
  localparam logic [3:0] FLD_STATION   = 4'd14;
  localparam logic [3:0] FLD_EXTRA     = 4'd15;

  localparam int unsigned NUM_FIELDS = 14;
  localparam int unsigned ACC_W      = 30;
  localparam int unsigned VAL_W      = 44;
  localparam logic [ACC_W-1:0] ACC_LIMIT = 30'd100000000;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [7:0] CH_M      = 8'h4D;

  // One received character together with its classification.
  typedef struct packed {
    logic [7:0] ch;
    logic       is_dollar;
    logic       is_comma;
    logic       is_star;
    logic       is_dot;
    logic       is_minus;
    logic       is_digit;
    logic       hex_ok;
    logic [3:0] nib;
  } byte_info_t;

  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    case (idx)
      3'd0:    hdr_char = 8'h47;
      3'd1:    hdr_char = 8'h50;
      3'd2:    hdr_char = 8'h47;
      3'd3:    hdr_char = 8'h47;
      3'd4:    hdr_char = 8'h41;
      default: hdr_char = 8'h00;
    endcase
  endfunction

  function automatic logic [3:0] flag_bit(input logic [3:0] k);
    case (k)
      FLD_TIME:     flag_bit = 4'd0;
      FLD_LAT:      flag_bit = 4'd1;
      FLD_LAT_DIR:  flag_bit = 4'd2;
      FLD_LON:      flag_bit = 4'd3;
      FLD_LON_DIR:  flag_bit = 4'd4;
      FLD_QUALITY:  flag_bit = 4'd7;
      FLD_SATS:     flag_bit = 4'd8;
      FLD_HDOP:     flag_bit = 4'd9;
      FLD_ALT:      flag_bit = 4'd5;
      FLD_ALT_UNIT: flag_bit = 4'd6;
      FLD_GEOID:    flag_bit = 4'd10;
      FLD_GEO_UNIT: flag_bit = 4'd11;
      FLD_AGE:      flag_bit = 4'd12;
      FLD_STATION:  flag_bit = 4'd13;
      default:      flag_bit = 4'd0;
    endcase
  endfunction

  function automatic logic [2:0] frac_lim(input logic [3:0] k);
    case (k)
      FLD_LAT, FLD_LON:   frac_lim = 3'd4;
      FLD_HDOP, FLD_AGE:  frac_lim = 3'd2;
      FLD_ALT, FLD_GEOID: frac_lim = 3'd1;
      default:            frac_lim = 3'd0;
    endcase
  endfunction

  function automatic logic is_indicator(input logic [3:0] k);
    is_indicator = (k == FLD_LAT_DIR) || (k == FLD_LON_DIR) ||
                   (k == FLD_ALT_UNIT) || (k == FLD_GEO_UNIT);
  endfunction

  function automatic logic [13:0] pow10(input logic [2:0] n);
    case (n)
      3'd0:    pow10 = 14'd1;
      3'd1:    pow10 = 14'd10;
      3'd2:    pow10 = 14'd100;
      3'd3:    pow10 = 14'd1000;
      3'd4:    pow10 = 14'd10000;
      default: pow10 = 14'd1;
    endcase
  endfunction

endpackage

// ===== rtl/core/ngga_front.sv =====
// Front end: classifies each received character and queues it.
// Depends on ngga_pkg (byte_info_t).
module ngga_front
  import ngga_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       deq_valid,
  input  logic       deq_ready,
  output byte_info_t deq_info
);

  byte_info_t slots_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;
  byte_info_t info_in;

  always_comb begin
    info_in           = '0;
    info_in.ch        = in_byte;
    info_in.is_dollar = (in_byte == CH_DOLLAR);
    info_in.is_comma  = (in_byte == CH_COMMA);
    info_in.is_star   = (in_byte == CH_STAR);
    info_in.is_dot    = (in_byte == CH_DOT);
    info_in.is_minus  = (in_byte == CH_MINUS);
    info_in.is_digit  = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    if (info_in.is_digit) begin
      info_in.hex_ok = 1'b1;
      info_in.nib    = in_byte[3:0];
    end else if ((in_byte >= 8'h41 && in_byte <= 8'h46) ||
                 (in_byte >= 8'h61 && in_byte <= 8'h66)) begin
      info_in.hex_ok = 1'b1;
      info_in.nib    = 4'(in_byte[2:0] + 3'd1) + 4'd8;
    end
  end

  assign in_ready  = (count_r != 2'd2);
  assign deq_valid = (count_r != 2'd0);
  assign deq_info  = slots_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = deq_valid && deq_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= info_in;
    end
  end

endmodule

// ===== rtl/core/ngga_back.sv =====
// Back end: sentence state machine, field conversion and the record register.
// Depends on ngga_pkg (phase_t, byte_info_t, field codes, lookup functions).
module ngga_back
  import ngga_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               deq_valid,
  output logic               deq_ready,
  input  byte_info_t         deq_info,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_frame_status,
  output logic [27:0]        out_field_flags,
  output logic [19:0]        out_utc_hhmmss,
  output logic signed [27:0] out_latitude_value,
  output logic signed [30:0] out_longitude_value,
  output logic [3:0]         out_fix_quality,
  output logic [3:0]         out_satellites_used,
  output logic [16:0]        out_hdop_hundredths,
  output logic signed [20:0] out_altitude_tenths,
  output logic signed [20:0] out_geoid_tenths,
  output logic [16:0]        out_dgps_age_hundredths,
  output logic [9:0]         out_station_id
);

  phase_t           phase_r, phase_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [3:0]       fn_r, fn_nxt;
  logic [3:0]       chars_r, chars_nxt;
  logic             hdr_ok_r, hdr_ok_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [3:0]       dot_r, dot_nxt;
  logic [2:0]       frac_r, frac_nxt;
  logic             neg_r, neg_nxt;
  logic             bad_r, bad_nxt;
  logic [3:0]       ck_hi_r, ck_hi_nxt;
  logic [27:0]      flags_r, flags_nxt;
  logic [19:0]      utc_r, utc_nxt;
  logic [27:0]      lat_r, lat_nxt;
  logic [30:0]      lon_r, lon_nxt;
  logic [3:0]       qual_r, qual_nxt;
  logic [3:0]       sats_r, sats_nxt;
  logic [16:0]      hdop_r, hdop_nxt;
  logic [20:0]      alt_r, alt_nxt;
  logic [20:0]      geoid_r, geoid_nxt;
  logic [16:0]      age_r, age_nxt;
  logic [9:0]       stn_r, stn_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             emit;
  logic [1:0]       status;

  // Finalization of the current field, from registered state only.
  logic [2:0]       lim, have;
  logic [VAL_W-1:0] v, neg_v;
  logic             fin_ok;
  logic [3:0]       fbit;
  logic [27:0]      fin_mask, empty_mask;
  logic [ACC_W-1:0] acc_push;
  logic [2:0]       frac_inc;
  logic             take, final_byte, can_emit, fld_active;

  always_comb begin
    lim   = frac_lim(fn_r);
    have  = (frac_r < lim) ? frac_r : lim;
    v     = VAL_W'(acc_r) * VAL_W'(pow10(lim - have));
    neg_v = VAL_W'(0) - v;
    fbit  = flag_bit(fn_r);
    case (fn_r)
      FLD_TIME:    fin_ok = !bad_r && chars_r <= 4'd10 && dot_r == 4'd7;
      FLD_LAT:     fin_ok = !bad_r && chars_r <= 4'd9 && dot_r == 4'd5;
      FLD_LON:     fin_ok = !bad_r && chars_r <= 4'd10 && dot_r == 4'd6;
      FLD_LAT_DIR: fin_ok = chars_r == 4'd1 &&
                            (v == VAL_W'(CH_N) || v == VAL_W'(CH_S));
      FLD_LON_DIR: fin_ok = chars_r == 4'd1 &&
                            (v == VAL_W'(CH_E) || v == VAL_W'(CH_W));
      FLD_ALT_UNIT, FLD_GEO_UNIT: fin_ok = chars_r == 4'd1 && v == VAL_W'(CH_M);
      FLD_QUALITY: fin_ok = !bad_r && chars_r == 4'd1 && dot_r == 4'd0 &&
                            v <= VAL_W'(8);
      FLD_SATS:    fin_ok = !bad_r && chars_r <= 4'd2 && dot_r == 4'd0 &&
                            v <= VAL_W'(12);
      FLD_HDOP, FLD_AGE: fin_ok = !bad_r && v <= VAL_W'(99999);
      FLD_ALT, FLD_GEOID: fin_ok = !bad_r && v <= VAL_W'(999999);
      default:     fin_ok = !bad_r && chars_r == 4'd4 && dot_r == 4'd0 &&
                            v <= VAL_W'(1023);
    endcase
    if (chars_r == 4'd0) begin
      fin_mask = 28'd1 << fbit;
    end else if (!fin_ok) begin
      fin_mask = 28'd1 << (5'(fbit) + 5'd14);
    end else begin
      fin_mask = '0;
    end
    empty_mask = '0;
    for (int k = 1; k <= NUM_FIELDS; k++) begin
      if (fn_r < 4'(k)) begin
        empty_mask = empty_mask | (28'd1 << flag_bit(4'(k)));
      end
    end
    acc_push = (acc_r << 3) + (acc_r << 1) + ACC_W'(deq_info.nib);
    frac_inc = (frac_r < 3'd7) ? frac_r + 3'd1 : frac_r;
  end

  assign final_byte = (phase_r == PH_CK_LO || phase_r == PH_CK_LO_BAD) &&
                      !deq_info.is_dollar;
  assign can_emit   = !out_valid_r || out_ready;
  assign deq_ready  = !final_byte || can_emit;
  assign take       = deq_valid && deq_ready;
  assign fld_active = (fn_r >= FLD_TIME) && (fn_r <= FLD_STATION);

  always_comb begin
    phase_nxt = phase_r;   xor_nxt   = xor_r;    fn_nxt    = fn_r;
    chars_nxt = chars_r;   hdr_ok_nxt = hdr_ok_r; acc_nxt  = acc_r;
    dot_nxt   = dot_r;     frac_nxt  = frac_r;   neg_nxt   = neg_r;
    bad_nxt   = bad_r;     ck_hi_nxt = ck_hi_r;  flags_nxt = flags_r;
    utc_nxt   = utc_r;     lat_nxt   = lat_r;    lon_nxt   = lon_r;
    qual_nxt  = qual_r;    sats_nxt  = sats_r;   hdop_nxt  = hdop_r;
    alt_nxt   = alt_r;     geoid_nxt = geoid_r;  age_nxt   = age_r;
    stn_nxt   = stn_r;
    emit      = 1'b0;
    status    = ST_VALID;
    out_valid_nxt = out_valid_r && !out_ready;

    if (take) begin
      if (deq_info.is_dollar) begin
        phase_nxt = PH_HEAD;  xor_nxt = '0;   fn_nxt = FLD_HEADER;
        hdr_ok_nxt = 1'b1;    ck_hi_nxt = '0; flags_nxt = '0;
        chars_nxt = '0; acc_nxt = '0; dot_nxt = '0; frac_nxt = '0;
        neg_nxt = 1'b0; bad_nxt = 1'b0;
        utc_nxt = '0; lat_nxt = '0; lon_nxt = '0; qual_nxt = '0; sats_nxt = '0;
        hdop_nxt = '0; alt_nxt = '0; geoid_nxt = '0; age_nxt = '0; stn_nxt = '0;
      end else begin
        case (phase_r)
          PH_HEAD: begin
            if (deq_info.is_comma) begin
              xor_nxt = xor_r ^ deq_info.ch;
              if (chars_r != 4'd5) hdr_ok_nxt = 1'b0;
              phase_nxt = PH_FIELDS;
              fn_nxt = FLD_TIME;
              chars_nxt = '0; acc_nxt = '0; dot_nxt = '0; frac_nxt = '0;
              neg_nxt = 1'b0; bad_nxt = 1'b0;
            end else if (deq_info.is_star) begin
              hdr_ok_nxt = 1'b0;
              phase_nxt = PH_CK_HI;
            end else begin
              xor_nxt = xor_r ^ deq_info.ch;
              if (chars_r >= 4'd5 || deq_info.ch != hdr_char(chars_r[2:0])) begin
                hdr_ok_nxt = 1'b0;
              end
              if (chars_r != 4'd15) chars_nxt = chars_r + 4'd1;
            end
          end
          PH_FIELDS: begin
            if (deq_info.is_comma || deq_info.is_star) begin
              if (deq_info.is_comma) begin
                xor_nxt = xor_r ^ deq_info.ch;
              end
              if (deq_info.is_comma && fn_r == FLD_STATION) begin
                // A fifteenth field: station is judged malformed outright.
                flags_nxt = flags_r | (28'd1 << (5'(flag_bit(FLD_STATION)) + 5'd14));
                stn_nxt = '0;
              end else if (fld_active) begin
                flags_nxt = flags_r | fin_mask;
                if (chars_r != 4'd0 && fin_ok) begin
                  case (fn_r)
                    FLD_TIME:    utc_nxt = v[19:0];
                    FLD_LAT:     lat_nxt = v[27:0];
                    FLD_LON:     lon_nxt = v[30:0];
                    FLD_LAT_DIR: if (v == VAL_W'(CH_S)) lat_nxt = 28'd0 - lat_r;
                    FLD_LON_DIR: if (v == VAL_W'(CH_W)) lon_nxt = 31'd0 - lon_r;
                    FLD_QUALITY: qual_nxt = v[3:0];
                    FLD_SATS:    sats_nxt = v[3:0];
                    FLD_HDOP:    hdop_nxt = v[16:0];
                    FLD_ALT:     alt_nxt = neg_r ? neg_v[20:0] : v[20:0];
                    FLD_GEOID:   geoid_nxt = neg_r ? neg_v[20:0] : v[20:0];
                    FLD_AGE:     age_nxt = v[16:0];
                    FLD_STATION: stn_nxt = v[9:0];
                    default: ;
                  endcase
                end
              end
              if (deq_info.is_comma) begin
                if (fn_r != FLD_EXTRA) fn_nxt = fn_r + 4'd1;
                chars_nxt = '0; acc_nxt = '0; dot_nxt = '0; frac_nxt = '0;
                neg_nxt = 1'b0; bad_nxt = 1'b0;
              end else begin
                // Fields that never arrived are flagged empty.
                flags_nxt = flags_r | fin_mask | empty_mask;
                if (!fld_active) flags_nxt = flags_r;
                phase_nxt = PH_CK_HI;
              end
            end else begin
              xor_nxt = xor_r ^ deq_info.ch;
              if (fld_active) begin
                if (is_indicator(fn_r)) begin
                  if (chars_r == 4'd0) acc_nxt = ACC_W'(deq_info.ch);
                end else if (deq_info.is_digit) begin
                  if (dot_r != 4'd0) begin
                    frac_nxt = frac_inc;
                    if (frac_inc <= lim) begin
                      if (acc_r >= ACC_LIMIT) bad_nxt = 1'b1;
                      else acc_nxt = acc_push;
                    end
                  end else begin
                    if (acc_r >= ACC_LIMIT) bad_nxt = 1'b1;
                    else acc_nxt = acc_push;
                  end
                end else if (deq_info.is_dot) begin
                  if (dot_r != 4'd0) bad_nxt = 1'b1;
                  else dot_nxt = (chars_r != 4'd15) ? chars_r + 4'd1 : 4'd15;
                end else if (deq_info.is_minus) begin
                  if ((fn_r == FLD_ALT || fn_r == FLD_GEOID) && chars_r == 4'd0) begin
                    neg_nxt = 1'b1;
                  end else begin
                    bad_nxt = 1'b1;
                  end
                end else begin
                  bad_nxt = 1'b1;
                end
                if (chars_r != 4'd15) chars_nxt = chars_r + 4'd1;
              end
            end
          end
          PH_CK_HI: begin
            if (deq_info.hex_ok) begin
              ck_hi_nxt = deq_info.nib;
              phase_nxt = PH_CK_LO;
            end else begin
              phase_nxt = PH_CK_LO_BAD;
            end
          end
          PH_CK_LO, PH_CK_LO_BAD: begin
            if (!hdr_ok_r) begin
              status = ST_BAD_HEADER;
            end else if (phase_r == PH_CK_LO_BAD || !deq_info.hex_ok ||
                         {ck_hi_r, deq_info.nib} != xor_r) begin
              status = ST_BAD_CKSUM;
            end else begin
              status = ST_VALID;
            end
            emit = 1'b1;
            out_valid_nxt = 1'b1;
            phase_nxt = PH_WAIT;
          end
          default: phase_nxt = PH_WAIT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;  xor_r <= '0;  fn_r <= FLD_HEADER; chars_r <= '0;
      hdr_ok_r <= 1'b1;    acc_r <= '0;  dot_r <= '0;  frac_r <= '0;
      neg_r <= 1'b0;       bad_r <= 1'b0; ck_hi_r <= '0; flags_r <= '0;
      utc_r <= '0; lat_r <= '0; lon_r <= '0; qual_r <= '0; sats_r <= '0;
      hdop_r <= '0; alt_r <= '0; geoid_r <= '0; age_r <= '0; stn_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;  xor_r <= xor_nxt;  fn_r <= fn_nxt;
      chars_r <= chars_nxt;  hdr_ok_r <= hdr_ok_nxt; acc_r <= acc_nxt;
      dot_r <= dot_nxt;      frac_r <= frac_nxt; neg_r <= neg_nxt;
      bad_r <= bad_nxt;      ck_hi_r <= ck_hi_nxt; flags_r <= flags_nxt;
      utc_r <= utc_nxt; lat_r <= lat_nxt; lon_r <= lon_nxt; qual_r <= qual_nxt;
      sats_r <= sats_nxt; hdop_r <= hdop_nxt; alt_r <= alt_nxt;
      geoid_r <= geoid_nxt; age_r <= age_nxt; stn_r <= stn_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Record register; a failed frame reports all zeros.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_frame_status        <= status;
      out_field_flags         <= (status == ST_VALID) ? flags_r : '0;
      out_utc_hhmmss          <= (status == ST_VALID) ? utc_r : '0;
      out_latitude_value      <= (status == ST_VALID) ? lat_r : '0;
      out_longitude_value     <= (status == ST_VALID) ? lon_r : '0;
      out_fix_quality         <= (status == ST_VALID) ? qual_r : '0;
      out_satellites_used     <= (status == ST_VALID) ? sats_r : '0;
      out_hdop_hundredths     <= (status == ST_VALID) ? hdop_r : '0;
      out_altitude_tenths     <= (status == ST_VALID) ? alt_r : '0;
      out_geoid_tenths        <= (status == ST_VALID) ? geoid_r : '0;
      out_dgps_age_hundredths <= (status == ST_VALID) ? age_r : '0;
      out_station_id          <= (status == ST_VALID) ? stn_r : '0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/nmea_gga_sentence_parser_core.sv =====
// Top level of the NMEA-0183 GGA sentence parser.
// Depends on ngga_pkg, ngga_front and ngga_back.
//
// Usage: characters of a sentence arrive one per request on the in_ channel
// (in_valid/in_ready, payload in_byte). A '$' starts a sentence at any point;
// bytes outside a sentence are dropped. After the second checksum digit that
// follows '*', one record request is presented on the out_ channel
// (out_valid/out_ready) with the frame status, empty and malformed flags for
// the fourteen fields and the converted fixed-point values.
// Throughput is one character per cycle unless the parser stalls (below).
// The front queue (two entries) takes a character whenever it has room; the
// back parser consumes one per cycle when not stalled. out_valid rises once
// the final checksum digit has passed the queue slot and the parser has
// set the record register.
// When the receiver stalls, the record register holds its request and the
// parser keeps consuming characters; only the last checksum digit of the
// next sentence waits until the record register is free; meanwhile the
// queue fills and in_ready drops.
// Reset (rst_n low, synchronous) empties the queue, drops any record in
// flight and makes the parser wait for a '$'.
module nmea_gga_sentence_parser_core
  import ngga_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_frame_status,
  output logic [27:0]        out_field_flags,
  output logic [19:0]        out_utc_hhmmss,
  output logic signed [27:0] out_latitude_value,
  output logic signed [30:0] out_longitude_value,
  output logic [3:0]         out_fix_quality,
  output logic [3:0]         out_satellites_used,
  output logic [16:0]        out_hdop_hundredths,
  output logic signed [20:0] out_altitude_tenths,
  output logic signed [20:0] out_geoid_tenths,
  output logic [16:0]        out_dgps_age_hundredths,
  output logic [9:0]         out_station_id
);

  // Classified characters travel from the front queue to the parser.
  logic       deq_valid;
  logic       deq_ready;
  byte_info_t deq_info;

  ngga_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .deq_valid (deq_valid),
    .deq_ready (deq_ready),
    .deq_info  (deq_info)
  );

  ngga_back u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .deq_valid               (deq_valid),
    .deq_ready               (deq_ready),
    .deq_info                (deq_info),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_frame_status        (out_frame_status),
    .out_field_flags         (out_field_flags),
    .out_utc_hhmmss          (out_utc_hhmmss),
    .out_latitude_value      (out_latitude_value),
    .out_longitude_value     (out_longitude_value),
    .out_fix_quality         (out_fix_quality),
    .out_satellites_used     (out_satellites_used),
    .out_hdop_hundredths     (out_hdop_hundredths),
    .out_altitude_tenths     (out_altitude_tenths),
    .out_geoid_tenths        (out_geoid_tenths),
    .out_dgps_age_hundredths (out_dgps_age_hundredths),
    .out_station_id          (out_station_id)
  );

endmodule

// ===== rtl/core/ngga_checker.sv =====
// Port-level checker for the GGA parser and its bind to the top level.
// Depends on ngga_pkg (status codes).
module ngga_checker
  import ngga_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_frame_status,
  input logic [27:0] out_field_flags,
  input logic [27:0] out_latitude_value,
  input logic [3:0]  out_fix_quality,
  input logic [3:0]  out_satellites_used,
  input logic [9:0]  out_station_id
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("record valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_field_flags) &&
    $stable(out_frame_status))
    else $error("stalled record changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_status != ST_VALID |->
    out_field_flags == '0 && out_latitude_value == '0 && out_station_id == '0)
    else $error("failed frame carries data");

  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_status != 2'd3 && out_fix_quality <= 4'd8 &&
    out_satellites_used <= 4'd12 && out_station_id <= 10'd1023)
    else $error("record field out of range");

endmodule

bind nmea_gga_sentence_parser_core ngga_checker u_ngga_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_frame_status    (out_frame_status),
  .out_field_flags     (out_field_flags),
  .out_latitude_value  (out_latitude_value),
  .out_fix_quality     (out_fix_quality),
  .out_satellites_used (out_satellites_used),
  .out_station_id      (out_station_id)
);
